[rtl/core/aarm_pkg.sv]
// Shared types, constants and rounding helpers for the axis-angle rotation matrix core.
// Depends on nothing; every module of the core imports it.
package aarm_pkg;

  localparam int unsigned DEF_COORD_FRAC_BITS = 16;
  localparam int unsigned DEF_ANGLE_FRAC_BITS = 28;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic signed [33:0] Q30_ONE_S = 34'sh0_4000_0000;

  // 2^40 / (2 pi): turns the angle magnitude into a phase of 2^-32 turn per unit.
  localparam logic [37:0] TURN_K = 38'd174992710548;
  localparam logic [18:0] TURN_K_LO = TURN_K[18:0];
  localparam logic [18:0] TURN_K_HI = TURN_K[37:19];

  // pi in Q32, split in halves for two narrower multipliers.
  localparam logic [33:0] PI_Q32 = 34'h3_243F_6A89;
  localparam logic [16:0] PI_LO = PI_Q32[16:0];
  localparam logic [16:0] PI_HI = PI_Q32[33:17];

  // Horner divisors. The sine series has one step less; its first entry is unused.
  localparam int unsigned HORNER_STEPS = 6;
  localparam int unsigned DIV_COS [HORNER_STEPS] = '{132, 90, 56, 30, 12, 2};
  localparam int unsigned DIV_SIN [HORNER_STEPS] = '{1, 110, 72, 42, 20, 6};

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    word_t px;
    word_t py;
    word_t pz;
    word_t angle;
    logic  inverse;
  } axis_ctx_t;

  typedef struct packed {
    word_t px;
    word_t py;
    word_t pz;
    word_t ux;
    word_t uy;
    word_t uz;
  } rot_ctx_t;

  // Arithmetic shift right by k, rounding half away from zero.
  function automatic logic signed [71:0] rnd_shr(input logic signed [71:0] v,
                                                 input int unsigned k);
    logic [71:0] mag;
    logic [71:0] res;
    mag = v[71] ? 72'(-v) : 72'(v);
    res = (mag + (72'd1 << (k - 1))) >> k;
    return v[71] ? -$signed(res) : $signed(res);
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic word_t sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -72'sd2147483648) return 32'sh8000_0000;
    return 32'(v);
  endfunction

endpackage

[rtl/core/aarm_hstep.sv]
// One Horner step h' = 1 - round(t2 * h) / DIVISOR in Q30, four register stages.
// Depends on aarm_pkg; the division is a reciprocal multiply with one correction.
module aarm_hstep import aarm_pkg::*; #(
  parameter int unsigned DIVISOR = 2
) (
  input  logic        clk,
  input  logic        ce,
  input  logic [29:0] t2,
  input  logic [30:0] h_in,
  output logic [30:0] h_out
);

  localparam int unsigned RSHIFT = 31 + $clog2(DIVISOR);
  localparam logic [31:0] RECIP = 32'((64'd1 << RSHIFT) / DIVISOR);
  localparam logic [30:0] DIV_W = 31'(DIVISOR);

  logic [60:0] prod;
  logic [30:0] x_b;
  logic [30:0] x_c;
  logic [62:0] xm;
  logic [30:0] q0;
  logic [30:0] rem;
  logic [30:0] quo;
  logic [61:0] rsum;

  always_comb begin
    rsum = 62'(prod) + (62'd1 << 29);
    q0 = 31'(xm >> RSHIFT);
    rem = x_c - 31'(q0 * DIV_W);
    quo = (rem >= DIV_W) ? q0 + 31'd1 : q0;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      prod <= 61'(t2) * 61'(h_in);
      x_b <= rsum[60:30];
      xm <= 63'(x_b) * 63'(RECIP);
      x_c <= x_b;
      h_out <= Q30_ONE - quo;
    end
  end

endmodule

[rtl/core/aarm_sincos.sv]
// Sine and cosine of the rotation angle in Q30: phase, octant fold, Horner series.
// Depends on aarm_pkg and aarm_hstep; carries the rotation context alongside.
module aarm_sincos import aarm_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     ce,
  input  logic     in_valid,
  input  word_t    angle,
  input  logic     inverse,
  input  rot_ctx_t in_ctx,
  output logic     out_valid,
  output word_t    sin_q30,
  output word_t    cos_q30,
  output rot_ctx_t out_ctx
);

  localparam int unsigned PH_SHIFT = ANGLE_FRAC_BITS + 8;
  localparam int unsigned HK_LEN = 4 * HORNER_STEPS + 1;
  localparam int unsigned LAT = 7 + 4 * HORNER_STEPS + 3;

  typedef struct packed {
    logic [2:0]  oct;
    logic [29:0] th;
    logic [29:0] t2;
  } hk_t;

  logic [LAT-1:0] vld;
  rot_ctx_t ctx_pipe [LAT];

  logic [31:0] mag_in;
  logic [50:0] s1_lo;
  logic [50:0] s1_hi;
  logic        s1_neg;
  logic [71:0] ph_sum;
  logic [31:0] s2_ph;
  logic [2:0]  s3_oct;
  logic [29:0] s3_r;
  logic [2:0]  s4_oct;
  logic [46:0] s4_lo;
  logic [46:0] s4_hi;
  logic [63:0] th_sum;
  logic [2:0]  s5_oct;
  logic [29:0] s5_th;
  logic [2:0]  s6_oct;
  logic [29:0] s6_th;
  logic [59:0] s6_sq;
  logic [60:0] t2_sum;
  hk_t         hk [HK_LEN];
  logic [30:0] hc_chain [HORNER_STEPS+1];
  logic [30:0] hs_chain [HORNER_STEPS+1];
  logic [60:0] f1_prod;
  logic [30:0] f1_cv;
  logic [2:0]  f1_oct;
  logic [61:0] sv_sum;
  logic [30:0] f2_sv;
  logic [30:0] f2_cv;
  logic [2:0]  f2_oct;
  logic [30:0] sin_mag;
  logic [30:0] cos_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_pipe[0] <= in_ctx;
      for (int i = 1; i < LAT; i++) ctx_pipe[i] <= ctx_pipe[i-1];
    end
  end

  always_comb begin
    mag_in = angle[31] ? 32'(-angle) : 32'(angle);
    ph_sum = (72'(s1_hi) << 19) + 72'(s1_lo) + (72'd1 << (PH_SHIFT - 1));
    th_sum = (64'(s4_hi) << 17) + 64'(s4_lo) + (64'd1 << 32);
    t2_sum = 61'(s6_sq) + (61'd1 << 29);
    sv_sum = 62'(f1_prod) + (62'd1 << 29);
  end

  // Phase, octant fold and reduced angle.
  always_ff @(posedge clk) begin
    if (ce) begin
      s1_lo <= 51'(mag_in) * 51'(TURN_K_LO);
      s1_hi <= 51'(mag_in) * 51'(TURN_K_HI);
      s1_neg <= angle[31] ^ inverse;
      s2_ph <= s1_neg ? 32'(-ph_sum[PH_SHIFT +: 32]) : ph_sum[PH_SHIFT +: 32];
      s3_oct <= s2_ph[31:29];
      s3_r <= s2_ph[29] ? 30'h2000_0000 - {1'b0, s2_ph[28:0]} : {1'b0, s2_ph[28:0]};
      s4_oct <= s3_oct;
      s4_lo <= 47'(s3_r) * 47'(PI_LO);
      s4_hi <= 47'(s3_r) * 47'(PI_HI);
      s5_oct <= s4_oct;
      s5_th <= th_sum[62:33];
      s6_oct <= s5_oct;
      s6_th <= s5_th;
      s6_sq <= 60'(s5_th) * 60'(s5_th);
      hk[0] <= '{oct: s6_oct, th: s6_th, t2: t2_sum[59:30]};
      for (int i = 1; i < HK_LEN; i++) hk[i] <= hk[i-1];
    end
  end

  assign hc_chain[0] = Q30_ONE;
  assign hs_chain[0] = Q30_ONE;
  assign hs_chain[1] = Q30_ONE;

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_step
    aarm_hstep #(.DIVISOR(DIV_COS[j])) u_cos (
      .clk   (clk),
      .ce    (ce),
      .t2    (hk[4*j].t2),
      .h_in  (hc_chain[j]),
      .h_out (hc_chain[j+1])
    );
    if (j > 0) begin : g_sin
      aarm_hstep #(.DIVISOR(DIV_SIN[j])) u_sin (
        .clk   (clk),
        .ce    (ce),
        .t2    (hk[4*j].t2),
        .h_in  (hs_chain[j]),
        .h_out (hs_chain[j+1])
      );
    end
  end

  // Octant map: sin and cos swap in octants 1, 2, 5 and 6, and take the signs of the quadrant.
  always_comb begin
    sin_mag = (f2_oct[0] ^ f2_oct[1]) ? f2_cv : f2_sv;
    cos_mag = (f2_oct[0] ^ f2_oct[1]) ? f2_sv : f2_cv;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f1_prod <= 61'(hk[HK_LEN-1].th) * 61'(hs_chain[HORNER_STEPS]);
      f1_cv <= hc_chain[HORNER_STEPS];
      f1_oct <= hk[HK_LEN-1].oct;
      f2_sv <= sv_sum[60:30];
      f2_cv <= f1_cv;
      f2_oct <= f1_oct;
      sin_q30 <= f2_oct[2] ? -word_t'({1'b0, sin_mag}) : word_t'({1'b0, sin_mag});
      cos_q30 <= (f2_oct[2] ^ f2_oct[1]) ? -word_t'({1'b0, cos_mag})
                                          : word_t'({1'b0, cos_mag});
    end
  end

  assign out_valid = vld[LAT-1];
  assign out_ctx = ctx_pipe[LAT-1];

endmodule

[rtl/core/aarm_axis.sv]
// Unit axis in Q30: normalize, sum of squares, bit-serial square root, long division.
// Depends on aarm_pkg; carries the pivot and angle context alongside.
module aarm_axis import aarm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      ce,
  input  logic      in_valid,
  input  word_t     axis_x,
  input  word_t     axis_y,
  input  word_t     axis_z,
  input  axis_ctx_t in_ctx,
  output logic      out_valid,
  output word_t     unit_x,
  output word_t     unit_y,
  output word_t     unit_z,
  output axis_ctx_t out_ctx
);

  localparam int unsigned NORM_STEPS = 5;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned QUOT_BITS = 31;
  localparam int unsigned LAT = 1 + NORM_STEPS + 2 + ROOT_STEPS + 1 + QUOT_BITS + 1;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } axis_aux_t;

  logic [LAT-1:0] vld;
  axis_ctx_t ctx_pipe [LAT];
  axis_aux_t aux_pipe [LAT];

  word_t       ax_in [3];
  logic [31:0] mag_in [3];
  logic [31:0] mx_in;
  logic [31:0] magn [NORM_STEPS+1][3];
  logic [31:0] mxn [NORM_STEPS+1];
  logic [63:0] sq [3];
  logic [31:0] mag_sq [3];
  logic [63:0] rad [ROOT_STEPS+1];
  logic [63:0] root [ROOT_STEPS+1];
  logic [31:0] rmag [ROOT_STEPS+1][3];
  logic [63:0] root_trial [ROOT_STEPS];
  logic [31:0] dm [QUOT_BITS+1];
  logic [63:0] rem [QUOT_BITS+1][3];
  logic [30:0] quo [QUOT_BITS+1][3];
  logic [63:0] dsub [QUOT_BITS];
  word_t       u_next [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_comb begin
    ax_in[0] = axis_x;
    ax_in[1] = axis_y;
    ax_in[2] = axis_z;
    for (int k = 0; k < 3; k++) mag_in[k] = ax_in[k][31] ? 32'(-ax_in[k]) : 32'(ax_in[k]);
    mx_in = mag_in[0];
    if (mag_in[1] > mx_in) mx_in = mag_in[1];
    if (mag_in[2] > mx_in) mx_in = mag_in[2];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_pipe[0] <= in_ctx;
      aux_pipe[0] <= '{neg: {axis_z[31], axis_y[31], axis_x[31]}, zero: (mx_in == 32'd0)};
      for (int i = 1; i < LAT; i++) begin
        ctx_pipe[i] <= ctx_pipe[i-1];
        aux_pipe[i] <= aux_pipe[i-1];
      end
    end
  end

  // Magnitudes, then a five-step shift that brings the largest one to at least 2^30.
  always_ff @(posedge clk) begin
    if (ce) begin
      magn[0] <= mag_in;
      mxn[0] <= mx_in;
      for (int i = 0; i < NORM_STEPS; i++) begin
        if (mxn[i] < (32'd1 << (31 - (16 >> i)))) begin
          mxn[i+1] <= mxn[i] << (16 >> i);
          for (int k = 0; k < 3; k++) magn[i+1][k] <= magn[i][k] << (16 >> i);
        end else begin
          mxn[i+1] <= mxn[i];
          for (int k = 0; k < 3; k++) magn[i+1][k] <= magn[i][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        sq[k] <= 64'(magn[NORM_STEPS][k]) * 64'(magn[NORM_STEPS][k]);
        mag_sq[k] <= magn[NORM_STEPS][k];
      end
      rad[0] <= sq[0] + sq[1] + sq[2];
      root[0] <= '0;
      rmag[0] <= mag_sq;
    end
  end

  // Square root, one result bit per stage.
  always_comb begin
    for (int i = 0; i < ROOT_STEPS; i++) root_trial[i] = root[i] + (64'd1 << (62 - 2 * i));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < ROOT_STEPS; i++) begin
        rmag[i+1] <= rmag[i];
        if (rad[i] >= root_trial[i]) begin
          rad[i+1] <= rad[i] - root_trial[i];
          root[i+1] <= (root[i] >> 1) + (64'd1 << (62 - 2 * i));
        end else begin
          rad[i+1] <= rad[i];
          root[i+1] <= root[i] >> 1;
        end
      end
    end
  end

  // Rounded quotient mag * 2^30 / m, restoring division with one quotient bit per stage.
  always_comb begin
    for (int i = 0; i < QUOT_BITS; i++) dsub[i] = 64'(dm[i]) << (QUOT_BITS - 1 - i);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dm[0] <= root[ROOT_STEPS][31:0];
      for (int k = 0; k < 3; k++) begin
        rem[0][k] <= (64'(rmag[ROOT_STEPS][k]) << 30) + (root[ROOT_STEPS] >> 1);
        quo[0][k] <= '0;
      end
      for (int i = 0; i < QUOT_BITS; i++) begin
        dm[i+1] <= dm[i];
        for (int k = 0; k < 3; k++) begin
          if (rem[i][k] >= dsub[i]) begin
            rem[i+1][k] <= rem[i][k] - dsub[i];
            quo[i+1][k] <= quo[i][k] | (31'd1 << (QUOT_BITS - 1 - i));
          end else begin
            rem[i+1][k] <= rem[i][k];
            quo[i+1][k] <= quo[i][k];
          end
        end
      end
    end
  end

  // Signs back on; an all-zero axis becomes the x axis.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (aux_pipe[LAT-2].zero) begin
        u_next[k] = (k == 0) ? word_t'({1'b0, Q30_ONE}) : '0;
      end else if (aux_pipe[LAT-2].neg[k]) begin
        u_next[k] = -word_t'({1'b0, quo[QUOT_BITS][k]});
      end else begin
        u_next[k] = word_t'({1'b0, quo[QUOT_BITS][k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      unit_x <= u_next[0];
      unit_y <= u_next[1];
      unit_z <= u_next[2];
    end
  end

  assign out_valid = vld[LAT-1];
  assign out_ctx = ctx_pipe[LAT-1];

endmodule

[rtl/core/aarm_rodrigues.sv]
// Rodrigues rotation entries and the pivot translation column, rounded and saturated.
// Depends on aarm_pkg; the last stage is the output register of the core.
module aarm_rodrigues import aarm_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         ce,
  input  logic         in_valid,
  input  word_t        sin_q30,
  input  word_t        cos_q30,
  input  rot_ctx_t     in_ctx,
  output logic         out_valid,
  output logic [383:0] mdata
);

  localparam int unsigned LAT = 9;
  localparam int unsigned OUT_SHIFT = 30 - COORD_FRAC_BITS;

  logic [LAT-1:0] vld;
  rot_ctx_t ctx_pipe [LAT];

  word_t              u_in [3];
  word_t              p5 [3];
  word_t              p6 [3];
  logic signed [63:0] r1_uu [6];
  logic signed [63:0] r1_us [3];
  logic signed [33:0] r1_t;
  word_t              r1_cs;
  logic signed [33:0] r2_uu [6];
  logic signed [33:0] r2_us [3];
  logic signed [33:0] r2_t;
  word_t              r2_cs;
  logic signed [67:0] r3_ut [6];
  logic signed [33:0] r3_us [3];
  word_t              r3_cs;
  logic signed [33:0] r4_ut [6];
  logic signed [33:0] r4_us [3];
  word_t              r4_cs;
  logic signed [34:0] rm [3][3];
  logic signed [66:0] rp [3][3];
  word_t              ro6 [3][3];
  logic signed [69:0] acc7 [3];
  logic signed [66:0] rp7 [3];
  word_t              ro7 [3][3];
  logic signed [69:0] acc8 [3];
  word_t              ro8 [3][3];
  word_t              mo [3][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ctx_pipe[0] <= in_ctx;
      for (int i = 1; i < LAT; i++) ctx_pipe[i] <= ctx_pipe[i-1];
    end
  end

  always_comb begin
    u_in[0] = in_ctx.ux;
    u_in[1] = in_ctx.uy;
    u_in[2] = in_ctx.uz;
    p5[0] = ctx_pipe[4].px;
    p5[1] = ctx_pipe[4].py;
    p5[2] = ctx_pipe[4].pz;
    p6[0] = ctx_pipe[5].px;
    p6[1] = ctx_pipe[5].py;
    p6[2] = ctx_pipe[5].pz;
  end

  // Products are ordered xx, yy, zz, xy, xz, yz; sine terms x, y, z.
  always_ff @(posedge clk) begin
    if (ce) begin
      r1_uu[0] <= 64'(u_in[0]) * 64'(u_in[0]);
      r1_uu[1] <= 64'(u_in[1]) * 64'(u_in[1]);
      r1_uu[2] <= 64'(u_in[2]) * 64'(u_in[2]);
      r1_uu[3] <= 64'(u_in[0]) * 64'(u_in[1]);
      r1_uu[4] <= 64'(u_in[0]) * 64'(u_in[2]);
      r1_uu[5] <= 64'(u_in[1]) * 64'(u_in[2]);
      for (int k = 0; k < 3; k++) r1_us[k] <= 64'(u_in[k]) * 64'(sin_q30);
      r1_t <= Q30_ONE_S - 34'(cos_q30);
      r1_cs <= cos_q30;

      for (int k = 0; k < 6; k++) r2_uu[k] <= 34'(rnd_shr(72'(r1_uu[k]), 30));
      for (int k = 0; k < 3; k++) r2_us[k] <= 34'(rnd_shr(72'(r1_us[k]), 30));
      r2_t <= r1_t;
      r2_cs <= r1_cs;

      for (int k = 0; k < 6; k++) r3_ut[k] <= 68'(r2_uu[k]) * 68'(r2_t);
      r3_us <= r2_us;
      r3_cs <= r2_cs;

      for (int k = 0; k < 6; k++) r4_ut[k] <= 34'(rnd_shr(72'(r3_ut[k]), 30));
      r4_us <= r3_us;
      r4_cs <= r3_cs;

      rm[0][0] <= 35'(r4_cs) + 35'(r4_ut[0]);
      rm[0][1] <= 35'(r4_ut[3]) - 35'(r4_us[2]);
      rm[0][2] <= 35'(r4_ut[4]) + 35'(r4_us[1]);
      rm[1][0] <= 35'(r4_ut[3]) + 35'(r4_us[2]);
      rm[1][1] <= 35'(r4_cs) + 35'(r4_ut[1]);
      rm[1][2] <= 35'(r4_ut[5]) - 35'(r4_us[0]);
      rm[2][0] <= 35'(r4_ut[4]) - 35'(r4_us[1]);
      rm[2][1] <= 35'(r4_ut[5]) + 35'(r4_us[0]);
      rm[2][2] <= 35'(r4_cs) + 35'(r4_ut[2]);

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rp[i][j] <= 67'(rm[i][j]) * 67'(p5[j]);
          ro6[i][j] <= sat32(rnd_shr(72'(rm[i][j]), OUT_SHIFT));
        end
      end

      for (int i = 0; i < 3; i++) begin
        acc7[i] <= (70'(p6[i]) <<< 30) - 70'(rp[i][0]) - 70'(rp[i][1]);
        rp7[i] <= rp[i][2];
      end
      ro7 <= ro6;

      for (int i = 0; i < 3; i++) acc8[i] <= acc7[i] - 70'(rp7[i]);
      ro8 <= ro7;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) mo[i][j] <= ro8[i][j];
        mo[i][3] <= sat32(rnd_shr(72'(acc8[i]), 30));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) mdata[(4 * i + j) * 32 +: 32] = mo[i][j];
    end
  end

  assign out_valid = vld[LAT-1];

endmodule

[rtl/core/axis_angle_rotation_matrix_core.sv]
// Top level of the axis-angle rotation matrix core: stream ports and pipeline control.
// Depends on aarm_pkg, aarm_axis, aarm_sincos and aarm_rodrigues.
//
// Channel   Direction  Beat contents
// s_axis    in         tdata: pivot x, y, z, axis x, y, z, angle; tuser: inverse flag
// m_axis    out        tdata: m00 m01 m02 m03 m10 m11 m12 m13 m20 m21 m22 m23
//
// The core takes one beat per cycle whenever it is not stalled. The pipeline has
// 73 stages for the unit axis (set by the 32-step square root and the 31-step
// division), 34 for sine and cosine (six Horner steps of four stages each) and
// 9 for the matrix and translation. All stages advance together whenever the
// output register is empty or being read, so a stall holds every beat in place.
// Reset (rst, synchronous) clears only the valid bits of the stages.
module axis_angle_rotation_matrix_core import aarm_pkg::*; #(
  parameter int unsigned COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
  parameter int unsigned ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x, point_y, point_z, axis_x, axis_y, axis_z, angle (32 bits each, lowest first)
  input  logic [223:0] s_axis_tdata,
  // inverse
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23 (32 bits each, lowest first)
  output logic [383:0] m_axis_tdata
);

  // The whole pipeline moves when the output register can take a new beat.
  logic      ce;
  axis_ctx_t in_ctx;
  logic      ax_valid;
  word_t     unit_x;
  word_t     unit_y;
  word_t     unit_z;
  axis_ctx_t ax_ctx;
  rot_ctx_t  rot_ctx;
  logic      sc_valid;
  word_t     sin_q30;
  word_t     cos_q30;
  rot_ctx_t  sc_ctx;

  assign ce = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ce;

  assign in_ctx = '{px: s_axis_tdata[31:0], py: s_axis_tdata[63:32],
                    pz: s_axis_tdata[95:64], angle: s_axis_tdata[223:192],
                    inverse: s_axis_tuser};

  aarm_axis u_axis (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_axis_tvalid),
    .axis_x    (s_axis_tdata[127:96]),
    .axis_y    (s_axis_tdata[159:128]),
    .axis_z    (s_axis_tdata[191:160]),
    .in_ctx    (in_ctx),
    .out_valid (ax_valid),
    .unit_x    (unit_x),
    .unit_y    (unit_y),
    .unit_z    (unit_z),
    .out_ctx   (ax_ctx)
  );

  // The pivot and the unit axis travel with the angle through the sine stages.
  assign rot_ctx = '{px: ax_ctx.px, py: ax_ctx.py, pz: ax_ctx.pz,
                     ux: unit_x, uy: unit_y, uz: unit_z};

  aarm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sincos (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (ax_valid),
    .angle     (ax_ctx.angle),
    .inverse   (ax_ctx.inverse),
    .in_ctx    (rot_ctx),
    .out_valid (sc_valid),
    .sin_q30   (sin_q30),
    .cos_q30   (cos_q30),
    .out_ctx   (sc_ctx)
  );

  // The last stage of the matrix unit is the output register of the core.
  aarm_rodrigues #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_rodrigues (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (sc_valid),
    .sin_q30   (sin_q30),
    .cos_q30   (cos_q30),
    .in_ctx    (sc_ctx),
    .out_valid (m_axis_tvalid),
    .mdata     (m_axis_tdata)
  );

endmodule
